/* hw/rtl/pmpc_pkg.sv */
package pmpc_pkg;

  localparam int GAIN_W        = 24;
  localparam int POS_W         = 16;
  localparam int SPEED_W       = 12;
  localparam int ERR_W         = 18;
  localparam int ISUM_W        = 32;
  localparam int PROD_P_W      = ERR_W + GAIN_W + 1;
  localparam int PROD_I_W      = ISUM_W + GAIN_W + 1;
  localparam int PROD_D_W      = ERR_W + GAIN_W + 1;
  localparam int SUM_W         = PROD_I_W + 1;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int GAIN_FRAC_DEF = 16;

  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 24'd6554;
  localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST = 24'd66;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 24'd9830;
  localparam logic [POS_W-1:0]   POS_LIMIT_RST  = 16'd25000;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 12'd1300;

  typedef enum logic [2:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_POS_LIMIT  = 3'd3,
    REG_SPEED_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic {
    KIND_STEP  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [POS_W-1:0]   position_limit;
    logic [SPEED_W-1:0] speed_limit;
  } cfg_t;

  typedef struct packed {
    logic                    fault;
    logic                    dir;
    logic signed [ERR_W-1:0] err;
    logic signed [ISUM_W-1:0] isum;
    logic signed [ERR_W-1:0] deriv;
  } front_t;

endpackage

/* hw/rtl/pmpc_cfg.sv */
module pmpc_cfg
  import pmpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop      <= GAIN_PROP_RST;
      cfg.gain_integ     <= GAIN_INTEG_RST;
      cfg.gain_deriv     <= GAIN_DERIV_RST;
      cfg.position_limit <= POS_LIMIT_RST;
      cfg.speed_limit    <= SPEED_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_GAIN_PROP:   cfg.gain_prop      <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg.gain_integ     <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg.gain_deriv     <= pwdata[GAIN_W-1:0];
        REG_POS_LIMIT:   cfg.position_limit <= pwdata[POS_W-1:0];
        REG_SPEED_LIMIT: cfg.speed_limit    <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_PROP:   prdata = DATA_W'(cfg.gain_prop);
      REG_GAIN_INTEG:  prdata = DATA_W'(cfg.gain_integ);
      REG_GAIN_DERIV:  prdata = DATA_W'(cfg.gain_deriv);
      REG_POS_LIMIT:   prdata = DATA_W'(cfg.position_limit);
      REG_SPEED_LIMIT: prdata = DATA_W'(cfg.speed_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/pmpc_front.sv */
module pmpc_front
  import pmpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [POS_W-1:0] target_position,
  input  logic [POS_W-1:0] measured_position,
  input  cfg_t             cfg,
  output logic             s1_valid,
  output front_t           s1,
  input  logic             s2_ready
);

  logic signed [ISUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0]  previous_error;
  logic signed [ISUM_W-1:0] error_sum_next;
  logic signed [ISUM_W:0]   acc;
  logic                     fault;
  logic [POS_W-1:0]         pos;
  logic                     accept;
  front_t                   s1_next;

  assign in_ready = !s1_valid || s2_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    fault = measured_position > cfg.position_limit;
    pos   = fault ? '0 : measured_position;
    s1_next.fault = fault;
    s1_next.err   = $signed({2'b00, target_position}) - $signed({2'b00, pos});
    acc = {error_sum[ISUM_W-1], error_sum} + (ISUM_W+1)'(s1_next.err);
    if (acc[ISUM_W] != acc[ISUM_W-1]) begin
      error_sum_next = acc[ISUM_W] ? {1'b1, {(ISUM_W-1){1'b0}}}
                                   : {1'b0, {(ISUM_W-1){1'b1}}};
    end else begin
      error_sum_next = acc[ISUM_W-1:0];
    end
    s1_next.isum  = error_sum_next;
    s1_next.deriv = s1_next.err - previous_error;
    s1_next.dir   = s1_next.err[ERR_W-1] || (s1_next.err == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        if (kind == KIND_CLEAR) begin
          error_sum      <= '0;
          previous_error <= '0;
        end else begin
          error_sum      <= error_sum_next;
          previous_error <= s1_next.err;
        end
      end
      if (in_ready) begin
        s1_valid <= in_valid && (kind == KIND_STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1 <= s1_next;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_CLEAR |=> error_sum == '0 && previous_error == '0)
    else $error("clear left history nonzero");

  a_fault_zeroes_pos: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_STEP && measured_position > cfg.position_limit |=>
      s1_valid && s1.fault && s1.err == $signed({2'b00, $past(target_position)}))
    else $error("fault word did not take measured position as zero");

  a_integ_monotone: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_STEP && !s1_next.err[ERR_W-1] |=>
      error_sum >= $past(error_sum))
    else $error("integral wrapped on positive error");

endmodule

/* hw/rtl/pmpc_back.sv */
module pmpc_back
  import pmpc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               s1_valid,
  input  front_t             s1,
  output logic               s2_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SPEED_W-1:0] motor_speed,
  output logic               direction,
  output logic               encoder_reset
);

  localparam int MAG_W = SUM_W - GAIN_FRAC_BITS;

  logic                       s2_valid;
  logic signed [PROD_P_W-1:0] p_prop;
  logic signed [PROD_I_W-1:0] p_integ;
  logic signed [PROD_D_W-1:0] p_deriv;
  logic                       s2_dir;
  logic                       s2_fault;

  logic                       s3_valid;
  logic                       s3_ready;
  logic signed [SUM_W-1:0]    sum;
  logic                       s3_dir;
  logic                       s3_fault;

  logic                       o_ready;
  logic signed [GAIN_W:0]     kp;
  logic signed [GAIN_W:0]     ki;
  logic signed [GAIN_W:0]     kd;
  logic signed [SUM_W-1:0]    sum_next;
  logic [SUM_W-1:0]           mag_full;
  logic [MAG_W-1:0]           mag;
  logic [SPEED_W-1:0]         speed_next;

  assign o_ready  = !out_valid || out_ready;
  assign s3_ready = !s3_valid || o_ready;
  assign s2_ready = !s2_valid || s3_ready;

  assign kp = $signed({1'b0, cfg.gain_prop});
  assign ki = $signed({1'b0, cfg.gain_integ});
  assign kd = $signed({1'b0, cfg.gain_deriv});

  always_comb begin
    sum_next = SUM_W'(p_prop) + SUM_W'(p_integ) + SUM_W'(p_deriv);
    mag_full = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    mag      = mag_full[SUM_W-1:GAIN_FRAC_BITS];
    if (mag > MAG_W'(cfg.speed_limit)) begin
      speed_next = cfg.speed_limit;
    end else begin
      speed_next = mag[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (o_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      p_prop   <= s1.err * kp;
      p_integ  <= s1.isum * ki;
      p_deriv  <= s1.deriv * kd;
      s2_dir   <= s1.dir;
      s2_fault <= s1.fault;
    end
    if (s3_ready) begin
      sum      <= sum_next;
      s3_dir   <= s2_dir;
      s3_fault <= s2_fault;
    end
    if (o_ready) begin
      motor_speed   <= speed_next;
      direction     <= s3_dir;
      encoder_reset <= s3_fault;
    end
  end

endmodule

/* hw/rtl/pid_motor_position_control.sv */
// Position PID controller: accepts one word per cycle while in_ready is high;
// a control step passes through the state stage, product stage, sum stage and
// then the output register to its result word, and a clear word zeroes the
// integral and last error in its acceptance cycle and gives no result. The
// integral and last error update in the cycle a word is accepted, so steps may
// follow each other in consecutive cycles; a stalled output holds every full
// stage, while empty stages still take words. Gains, position limit and speed
// limit sit behind the APB port at byte addresses 0, 4, 8, 12 and 16.
module pid_motor_position_control
  import pmpc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [POS_W-1:0]   target_position,
  input  logic [POS_W-1:0]   measured_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SPEED_W-1:0] motor_speed,
  output logic               direction,
  output logic               encoder_reset
);

  cfg_t   cfg;
  logic   s1_valid;
  front_t s1;
  logic   s2_ready;

  pmpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pmpc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .target_position   (target_position),
    .measured_position (measured_position),
    .cfg               (cfg),
    .s1_valid          (s1_valid),
    .s1                (s1),
    .s2_ready          (s2_ready)
  );

  pmpc_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .s2_ready      (s2_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .motor_speed   (motor_speed),
    .direction     (direction),
    .encoder_reset (encoder_reset)
  );

endmodule
